/* src/lctm_pkg.sv */
// ----------------------------------------------------------------------------
// lctm_pkg
// Shared types, constants and helpers of the LRU cache tag manager.
// ----------------------------------------------------------------------------
package lctm_pkg;

	// table geometry
	localparam int LINK_ENTRIES = 16;
	localparam int DATA_ENTRIES = 32;
	localparam int MAX_SLOTS    = 64;
	localparam int IDX_W        = $clog2(MAX_SLOTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int ADDR_W       = IDX_W + 1;
	localparam int MEM_DEPTH    = 2 * MAX_SLOTS;

	// field widths
	localparam int TAG_W   = 32;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 5;

	localparam logic [TAG_W-1:0]   TAG_INVALID = 32'hFFFF_FFFF;
	localparam logic [STAMP_W-1:0] STAMP_MAX   = 32'hFFFF_FFFF;
	localparam logic [STAMP_W-1:0] RENUM_AT    = 32'hFFFF_FFFE;

	typedef enum logic [1:0] {
		REQ_FIND    = 2'd0,
		REQ_ALLOC   = 2'd1,
		REQ_VICTIM  = 2'd2,
		REQ_DISCARD = 2'd3
	} req_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RN_LOAD,
		ST_RN_CAP,
		ST_RN_CMP,
		ST_RN_WR,
		ST_RN_COPY,
		ST_SCAN,
		ST_DONE
	} state_t;

	// control from the sequencer to the store
	typedef struct packed {
		logic [ADDR_W-1:0]  rd_addr;
		logic               tag_we;
		logic               stamp_we;
		logic [ADDR_W-1:0]  wr_addr;
		logic [TAG_W-1:0]   tag_wdata;
		logic [STAMP_W-1:0] stamp_wdata;
		logic               rank_we;
		logic [IDX_W-1:0]   rank_waddr;
		logic [IDX_W-1:0]   rank_wdata;
		logic [IDX_W-1:0]   rank_raddr;
		logic               discard;
		logic               discard_sel;
	} st_ctl_t;

	// registered read data from the store
	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
		logic [IDX_W-1:0]   rank;
	} st_dat_t;

	function automatic logic [CNT_W-1:0] table_entries(input logic sel);
		return sel ? CNT_W'(DATA_ENTRIES) : CNT_W'(LINK_ENTRIES);
	endfunction

endpackage

/* src/lctm_if.sv */
// ----------------------------------------------------------------------------
// lctm_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface lctm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic        table_sel;
	logic [31:0] tag;

	modport source (output valid, req_type, table_sel, tag, input ready);
	modport sink   (input valid, req_type, table_sel, tag, output ready);
endinterface

interface lctm_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [4:0]  slot;
	logic        evicted_valid;
	logic [31:0] evicted_tag;

	modport source (output valid, status, slot, evicted_valid, evicted_tag, input ready);
	modport sink   (input valid, status, slot, evicted_valid, evicted_tag, output ready);
endinterface

/* src/lctm_store.sv */
// ----------------------------------------------------------------------------
// lctm_store
// Tag, stamp and rank memories with registered reads.
// ----------------------------------------------------------------------------
module lctm_store
	import lctm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  st_ctl_t ctl,
	output st_dat_t dat
);

	logic [TAG_W-1:0]   tag_mem   [MEM_DEPTH];
	logic [STAMP_W-1:0] stamp_mem [MEM_DEPTH];
	logic [IDX_W-1:0]   rank_mem  [MAX_SLOTS];
	logic [MEM_DEPTH-1:0] tag_vld_q;
	logic [MEM_DEPTH-1:0] stamp_vld_q;

	// written flags: an unwritten tag reads invalid, an unwritten stamp zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_vld_q   <= '0;
			stamp_vld_q <= '0;
		end else begin
			if (ctl.discard) begin
				for (int i = 0; i < MEM_DEPTH; i++) begin
					if (i / MAX_SLOTS == int'(ctl.discard_sel))
						tag_vld_q[i] <= 1'b0;
				end
			end
			if (ctl.tag_we)
				tag_vld_q[ctl.wr_addr] <= 1'b1;
			if (ctl.stamp_we)
				stamp_vld_q[ctl.wr_addr] <= 1'b1;
		end
	end

	// tag memory
	always_ff @(posedge clk) begin
		if (ctl.tag_we)
			tag_mem[ctl.wr_addr] <= ctl.tag_wdata;
		dat.tag <= tag_vld_q[ctl.rd_addr] ? tag_mem[ctl.rd_addr] : TAG_INVALID;
	end

	// stamp memory
	always_ff @(posedge clk) begin
		if (ctl.stamp_we)
			stamp_mem[ctl.wr_addr] <= ctl.stamp_wdata;
		dat.stamp <= stamp_vld_q[ctl.rd_addr] ? stamp_mem[ctl.rd_addr] : '0;
	end

	// rank scratch memory for renumbering
	always_ff @(posedge clk) begin
		if (ctl.rank_we)
			rank_mem[ctl.rank_waddr] <= ctl.rank_wdata;
		dat.rank <= rank_mem[ctl.rank_raddr];
	end

endmodule

/* src/lru_cache_tag_manager_core.sv */
// ----------------------------------------------------------------------------
// lru_cache_tag_manager_core
// Two fully associative tag tables with LRU stamps, driven by a sequencer
// that scans the store memories one entry a cycle.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   req_type, table_sel, tag
//  rsp      out  status, slot, evicted_valid, evicted_tag
//
//  An item scans the entries of the chosen table one entry a cycle over the
//  tag/stamp memory read port and stops early on a hit: a matching tag for a
//  find, an invalid entry for an allocate or victim; a discard skips the scan.
//  When the stamp counter is due for renumbering before a find or allocate,
//  rank counting over the same port comes first.
//  Reset clears the written flags, the counters and the control state.
//  A result waits in the output register; the block stalls in its final
//  state only while a previous result is still untaken.
module lru_cache_tag_manager_core
	import lctm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	lctm_req_if.sink     req,
	lctm_rsp_if.source   rsp
);

	state_t state_q, state_nxt;
	st_ctl_t ctl;
	st_dat_t dat;

	req_op_t            op_q;
	logic               tsel_q;
	logic [TAG_W-1:0]   tag_q;
	logic [CNT_W-1:0]   n_q;
	logic [STAMP_W-1:0] cnt_q [2];

	logic [CNT_W-1:0]   idx_q;
	logic               chk_vld_s1;
	logic [IDX_W-1:0]   chk_idx_s1;

	logic               found_q;
	logic [IDX_W-1:0]   sel_q;
	logic [STAMP_W-1:0] oldest_q;
	logic               ev_vld_q;
	logic [TAG_W-1:0]   ev_tag_q;

	logic [CNT_W-1:0]   rn_i_q;
	logic [STAMP_W-1:0] rn_si_q;
	logic [IDX_W-1:0]   rn_cnt_q;

	logic               out_vld_q;
	logic               accept, go, last_s1, issuing, renum_due;
	logic               is_inv, hit, older, scan_stop, rn_less;
	req_op_t            in_op;

	lctm_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.dat    (dat)
	);

	// handshake and shared conditions
	assign in_op     = req_op_t'(req.req_type);
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign go        = !out_vld_q || rsp.ready;
	assign last_s1   = ({1'b0, chk_idx_s1} == n_q - CNT_W'(1));
	assign renum_due = (cnt_q[req.table_sel] >= RENUM_AT) &&
		(in_op == REQ_FIND || in_op == REQ_ALLOC);
	assign issuing   = (state_q == ST_RN_CMP || state_q == ST_RN_COPY ||
		state_q == ST_SCAN) && (state_nxt == state_q) && (idx_q < n_q);

	// entry evaluation during the scan
	always_comb begin
		is_inv = (dat.tag == TAG_INVALID);
		older  = 1'b0;
		unique case (op_q)
			REQ_FIND:    hit = (tag_q != TAG_INVALID) && (dat.tag == tag_q);
			REQ_ALLOC:   hit = is_inv;
			REQ_VICTIM: begin
				hit   = is_inv;
				older = !is_inv && (dat.stamp < oldest_q);
			end
			default:     hit = 1'b0;
		endcase
		scan_stop = chk_vld_s1 && (hit || last_s1);
		rn_less   = (dat.stamp < rn_si_q) ||
			((dat.stamp == rn_si_q) && (chk_idx_s1 < rn_i_q[IDX_W-1:0]));
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_op == REQ_DISCARD)
						state_nxt = ST_DONE;
					else if (renum_due)
						state_nxt = ST_RN_LOAD;
					else
						state_nxt = ST_SCAN;
				end
			end
			ST_RN_LOAD: state_nxt = ST_RN_CAP;
			ST_RN_CAP:  state_nxt = ST_RN_CMP;
			ST_RN_CMP: begin
				if (chk_vld_s1 && last_s1)
					state_nxt = ST_RN_WR;
			end
			ST_RN_WR: begin
				if (rn_i_q == n_q - CNT_W'(1))
					state_nxt = ST_RN_COPY;
				else
					state_nxt = ST_RN_LOAD;
			end
			ST_RN_COPY: begin
				if (chk_vld_s1 && last_s1)
					state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_stop)
					state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (go)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// store control
	always_comb begin
		ctl             = '0;
		ctl.rd_addr     = {tsel_q, idx_q[IDX_W-1:0]};
		ctl.rank_raddr  = idx_q[IDX_W-1:0];
		ctl.rank_waddr  = rn_i_q[IDX_W-1:0];
		ctl.rank_wdata  = rn_cnt_q;
		ctl.wr_addr     = {tsel_q, sel_q};
		ctl.tag_wdata   = tag_q;
		ctl.stamp_wdata = cnt_q[tsel_q];
		ctl.discard_sel = tsel_q;
		unique case (state_q)
			ST_RN_LOAD: ctl.rd_addr = {tsel_q, rn_i_q[IDX_W-1:0]};
			ST_RN_WR:   ctl.rank_we = 1'b1;
			ST_RN_COPY: begin
				ctl.stamp_we    = chk_vld_s1;
				ctl.wr_addr     = {tsel_q, chk_idx_s1};
				ctl.stamp_wdata = STAMP_W'(dat.rank);
			end
			ST_DONE: begin
				ctl.tag_we   = go && found_q && (op_q == REQ_ALLOC || op_q == REQ_VICTIM);
				ctl.stamp_we = go && found_q;
				ctl.discard  = go && (op_q == REQ_DISCARD);
			end
			default: ;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			chk_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
			cnt_q[0]   <= '0;
			cnt_q[1]   <= '0;
		end else begin
			state_q    <= state_nxt;
			chk_vld_s1 <= issuing;
			if (state_q == ST_DONE && go)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;
			// stamp counters
			if (state_q == ST_RN_COPY && state_nxt == ST_SCAN)
				cnt_q[tsel_q] <= STAMP_W'(n_q);
			else if (ctl.discard)
				cnt_q[tsel_q] <= '0;
			else if (ctl.stamp_we && state_q == ST_DONE)
				cnt_q[tsel_q] <= cnt_q[tsel_q] + STAMP_W'(1);
		end
	end

	// request and scan registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= in_op;
			tsel_q   <= req.table_sel;
			tag_q    <= req.tag;
			n_q      <= table_entries(req.table_sel);
			found_q  <= 1'b0;
			sel_q    <= '0;
			oldest_q <= STAMP_MAX;
			ev_vld_q <= 1'b0;
			ev_tag_q <= '0;
			rn_i_q   <= '0;
		end
		// walk index
		if (state_nxt != state_q)
			idx_q <= '0;
		else if (issuing)
			idx_q <= idx_q + CNT_W'(1);
		if (issuing)
			chk_idx_s1 <= idx_q[IDX_W-1:0];
		// scan results
		if (state_q == ST_SCAN && chk_vld_s1) begin
			if (hit) begin
				found_q  <= 1'b1;
				sel_q    <= chk_idx_s1;
				ev_vld_q <= 1'b0;
				ev_tag_q <= '0;
			end else if (older) begin
				found_q  <= 1'b1;
				sel_q    <= chk_idx_s1;
				oldest_q <= dat.stamp;
				ev_vld_q <= 1'b1;
				ev_tag_q <= dat.tag;
			end
		end
		// rank counting
		if (state_q == ST_RN_CAP) begin
			rn_si_q  <= dat.stamp;
			rn_cnt_q <= '0;
		end else if (state_q == ST_RN_CMP && chk_vld_s1 && rn_less) begin
			rn_cnt_q <= rn_cnt_q + IDX_W'(1);
		end
		if (state_q == ST_RN_WR)
			rn_i_q <= rn_i_q + CNT_W'(1);
		// result register
		if (state_q == ST_DONE && go) begin
			rsp.status        <= !(found_q || op_q == REQ_DISCARD);
			rsp.slot          <= found_q ? sel_q[SLOT_W-1:0] : '0;
			rsp.evicted_valid <= found_q && ev_vld_q;
			rsp.evicted_tag   <= found_q ? ev_tag_q : '0;
		end
	end

	assign rsp.valid = out_vld_q;

`ifndef SYNTHESIS
	// a failed request reports no slot and no eviction
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> rsp.slot == '0 && !rsp.evicted_valid)
		else $error("failed result carries slot or eviction");

	// an accepted item closes the input until its result is built
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("input open while an item is in work");

	// a reported eviction never carries the invalid mark
	a_evict_tag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.evicted_valid |-> rsp.evicted_tag != TAG_INVALID)
		else $error("evicted tag is the invalid mark");
`endif

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU cache tag manager. Request items are built
// in a queue and driven with random gaps; an in-bench model of both tag
// tables predicts each result. Results are taken with random back-pressure,
// including one long stall, and checked field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lctm_pkg::*;

	typedef struct {
		bit          drain;
		req_op_t     op;
		logic        tsel;
		logic [31:0] tag;
	} lookup_t;

	typedef struct packed {
		logic        status;
		logic [4:0]  slot;
		logic        ev_valid;
		logic [31:0] ev_tag;
	} outcome_t;

	logic clk;
	logic arst_n;

	lctm_req_if req ();
	lctm_rsp_if rsp ();

	lru_cache_tag_manager_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow of the tag tables
	logic [31:0] shadow_tag   [2][MAX_SLOTS];
	logic [31:0] shadow_stamp [2][MAX_SLOTS];
	logic [31:0] shadow_count [2];

	lookup_t     pending_lookups[$];
	outcome_t    expected_outcomes[$];
	logic [31:0] tag_pool[32];

	int  mismatches;
	bit  req_fire;
	int  tx_gap;
	int  rx_gap;
	bit  idle_on;
	bit  rx_hold;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int entries_of(input logic tsel);
		return tsel ? DATA_ENTRIES : LINK_ENTRIES;
	endfunction

	// stamps become their rank once the counter is near wrap
	function automatic void renumber_stamps(input logic tsel);
		logic [31:0] rank[MAX_SLOTS];
		int n;
		n = entries_of(tsel);
		if (shadow_count[tsel] < RENUM_AT)
			return;
		for (int i = 0; i < n; i++) begin
			rank[i] = 0;
			for (int j = 0; j < n; j++)
				if (shadow_stamp[tsel][j] < shadow_stamp[tsel][i] ||
				    (shadow_stamp[tsel][j] == shadow_stamp[tsel][i] && j < i))
					rank[i]++;
		end
		for (int i = 0; i < n; i++)
			shadow_stamp[tsel][i] = rank[i];
		shadow_count[tsel] = n;
	endfunction

	function automatic void touch(input logic tsel, input int idx);
		shadow_stamp[tsel][idx] = shadow_count[tsel];
		shadow_count[tsel] = shadow_count[tsel] + 1;
	endfunction

	function automatic outcome_t lookup_outcome(input lookup_t it);
		outcome_t r;
		int n;
		int idx;
		bit ok;
		logic [31:0] oldest;
		n = entries_of(it.tsel);
		idx = 0;
		ok = 1'b0;
		r = '0;
		case (it.op)
			REQ_FIND: begin
				renumber_stamps(it.tsel);
				if (it.tag != TAG_INVALID)
					for (int i = 0; i < n && !ok; i++)
						if (shadow_tag[it.tsel][i] == it.tag) begin
							touch(it.tsel, i);
							idx = i;
							ok = 1'b1;
						end
			end
			REQ_ALLOC: begin
				renumber_stamps(it.tsel);
				for (int i = 0; i < n && !ok; i++)
					if (shadow_tag[it.tsel][i] == TAG_INVALID) begin
						shadow_tag[it.tsel][i] = it.tag;
						touch(it.tsel, i);
						idx = i;
						ok = 1'b1;
					end
			end
			REQ_VICTIM: begin
				oldest = STAMP_MAX;
				for (int i = 0; i < n; i++) begin
					if (shadow_tag[it.tsel][i] == TAG_INVALID) begin
						idx = i;
						ok = 1'b1;
						break;
					end
					if (shadow_stamp[it.tsel][i] < oldest) begin
						oldest = shadow_stamp[it.tsel][i];
						idx = i;
						ok = 1'b1;
					end
				end
				if (ok) begin
					if (shadow_tag[it.tsel][idx] != TAG_INVALID) begin
						r.ev_valid = 1'b1;
						r.ev_tag = shadow_tag[it.tsel][idx];
					end
					shadow_tag[it.tsel][idx] = it.tag;
					touch(it.tsel, idx);
				end
			end
			default: begin
				for (int i = 0; i < n; i++)
					shadow_tag[it.tsel][i] = TAG_INVALID;
				shadow_count[it.tsel] = 0;
				ok = 1'b1;
			end
		endcase
		r.status = !ok;
		r.slot = ok ? idx[4:0] : 5'd0;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (!idle_on || p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic void push(input req_op_t op, input logic tsel, input logic [31:0] tag);
		lookup_t it;
		it.drain = 1'b0;
		it.op = op;
		it.tsel = tsel;
		it.tag = tag;
		pending_lookups.push_back(it);
	endfunction

	function automatic void push_drain();
		lookup_t it;
		it = '{1'b1, REQ_FIND, 1'b0, 32'd0};
		pending_lookups.push_back(it);
	endfunction

	// mostly pool tags so that finds hit, some fully random
	function automatic void push_random();
		int p;
		req_op_t op;
		logic [31:0] tag;
		p = $urandom_range(99);
		if (p < 40)
			op = REQ_FIND;
		else if (p < 62)
			op = REQ_ALLOC;
		else if (p < 97)
			op = REQ_VICTIM;
		else
			op = REQ_DISCARD;
		tag = ($urandom_range(99) < 85) ? tag_pool[$urandom_range(31)] : $urandom;
		push(op, $urandom_range(1), tag);
	endfunction

	// request driver, changes on the falling edge
	always @(negedge clk) begin
		lookup_t it;
		logic    nxt_valid;
		nxt_valid = req.valid;
		if (arst_n) begin
			if (req.valid && !req_fire) begin
				nxt_valid = 1'b1;
			end else if (tx_gap > 0) begin
				nxt_valid = 1'b0;
				tx_gap--;
			end else if (pending_lookups.size() > 0 && pending_lookups[0].drain) begin
				nxt_valid = 1'b0;
				if (expected_outcomes.size() == 0)
					void'(pending_lookups.pop_front());
			end else if (pending_lookups.size() > 0) begin
				it = pending_lookups.pop_front();
				req.req_type  <= it.op;
				req.table_sel <= it.tsel;
				req.tag       <= it.tag;
				nxt_valid = 1'b1;
				tx_gap = pick_gap();
			end else begin
				nxt_valid = 1'b0;
			end
			req.valid <= nxt_valid;
		end
	end

	// result receiver ready
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold) begin
				rsp.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rsp.ready <= 1'b0;
				rx_gap--;
			end else begin
				rsp.ready <= 1'b1;
				rx_gap = pick_gap();
			end
		end
	end

	// accept requests into the model and check results
	always @(posedge clk) begin
		lookup_t  it;
		outcome_t want;
		req_fire <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			it.drain = 1'b0;
			it.op = req_op_t'(req.req_type);
			it.tsel = req.table_sel;
			it.tag = req.tag;
			expected_outcomes.push_back(lookup_outcome(it));
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_outcomes.size() == 0) begin
				report("unexpected result, status", rsp.status, 32'd0);
			end else begin
				want = expected_outcomes.pop_front();
				if (rsp.status !== want.status)
					report("status", rsp.status, want.status);
				if (rsp.slot !== want.slot)
					report("slot", rsp.slot, want.slot);
				if (rsp.evicted_valid !== want.ev_valid)
					report("evicted_valid", rsp.evicted_valid, want.ev_valid);
				if (rsp.evicted_tag !== want.ev_tag)
					report("evicted_tag", rsp.evicted_tag, want.ev_tag);
			end
		end
	end

	// stimulus and end of run
	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_FIND;
		req.table_sel = 1'b0;
		req.tag = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		tx_gap = 0;
		rx_gap = 0;
		idle_on = 1'b1;
		rx_hold = 1'b0;
		for (int t = 0; t < 2; t++) begin
			shadow_count[t] = '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				shadow_tag[t][i] = TAG_INVALID;
				shadow_stamp[t][i] = '0;
			end
		end
		tag_pool[0] = 32'd0;
		tag_pool[1] = 32'hFFFF_FFFD;
		for (int i = 2; i < 32; i++)
			tag_pool[i] = $urandom_range(32'hFFFF_FFFD);

		// directed opening
		push(REQ_FIND, 1'b0, 32'd0);
		push(REQ_FIND, 1'b1, TAG_INVALID);
		push(REQ_VICTIM, 1'b1, 32'h0000_0055);
		push(REQ_ALLOC, 1'b0, 32'd0);
		push(REQ_ALLOC, 1'b0, 32'hFFFF_FFFD);
		push(REQ_ALLOC, 1'b0, TAG_INVALID);
		push(REQ_FIND, 1'b0, TAG_INVALID);
		push(REQ_FIND, 1'b0, 32'hFFFF_FFFD);
		push(REQ_FIND, 1'b0, 32'd0);
		push(REQ_ALLOC, 1'b1, 32'hAAAA_AAAA);
		push(REQ_ALLOC, 1'b1, 32'h5555_5555);
		push(REQ_VICTIM, 1'b0, 32'h1234_5678);
		push(REQ_VICTIM, 1'b0, TAG_INVALID);
		push(REQ_DISCARD, 1'b0, 32'd0);
		push(REQ_FIND, 1'b0, 32'd0);
		push(REQ_DISCARD, 1'b1, 32'hFFFF_FFFD);
		// fill the link table and overflow it
		for (int i = 0; i <= LINK_ENTRIES; i++)
			push(REQ_ALLOC, 1'b0, tag_pool[i]);
		push(REQ_VICTIM, 1'b0, 32'h0BAD_F00D);
		push(REQ_VICTIM, 1'b0, 32'hF00D_0BAD);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// random phase with long receiver stall
		for (int i = 0; i < 400; i++)
			push_random();
		wait (pending_lookups.size() < 350);
		rx_hold = 1'b1;
		repeat (600) @(posedge clk);
		rx_hold = 1'b0;

		// sender pause until all results are in, then random items, then a run with no idling
		push_drain();
		for (int i = 0; i < 300; i++)
			push_random();
		wait (pending_lookups.size() == 0);
		idle_on = 1'b0;
		for (int i = 0; i < 200; i++)
			push_random();
		wait (pending_lookups.size() == 0);
		idle_on = 1'b1;
		push_drain();
		for (int i = 0; i < 320; i++)
			push_random();

		wait (pending_lookups.size() == 0 && !req.valid && expected_outcomes.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// timeout
	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* lru_cache_tag_manager_core.f */
src/lctm_pkg.sv
src/lctm_if.sv
src/lctm_store.sv
src/lru_cache_tag_manager_core.sv
sim/testbench.sv
